FILE: sv/pipwt_pkg.sv
package pipwt_pkg;

  // Boundary tolerance register width and its value after reset
  localparam int unsigned TOL_W     = 16;
  localparam int unsigned TOL_RESET = 7;

  // One unit in Q16.16
  localparam int unsigned QONE = 65536;

  // Configuration register index
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_X      = 2'd0,
    REG_QUERY_Y      = 2'd1,
    REG_NONZERO_RULE = 2'd2,
    REG_BOUNDARY_TOL = 2'd3
  } cfg_reg_e;

  // Verdict on one edge; hit and xing already qualified by the edge being present
  typedef struct packed {
    logic hit;    // query point on the edge within tolerance
    logic xing;   // rightward ray crosses the edge
    logic up;     // edge runs toward larger y
  } edge_res_t;

endpackage

FILE: sv/pipwt_edge.sv
module pipwt_edge #(
  parameter int CW = 32
) (
  input  logic                           clk_i,
  input  logic                           en1_i,
  input  logic                           en2_i,
  input  logic                           en3_i,
  input  logic                           ok_i,
  input  logic signed [CW-1:0]           sx_i,
  input  logic signed [CW-1:0]           sy_i,
  input  logic signed [CW-1:0]           ex_i,
  input  logic signed [CW-1:0]           ey_i,
  input  logic signed [CW-1:0]           qx_i,
  input  logic signed [CW-1:0]           qy_i,
  input  logic [pipwt_pkg::TOL_W-1:0]    tol_i,
  output pipwt_pkg::edge_res_t           res_o
);
  import pipwt_pkg::*;

  localparam int DW  = CW + 1;                 // coordinate difference
  localparam int SW  = DW + 2;                 // 1.0 + |dx| + |dy|
  localparam int TW  = int'(TOL_W) + SW;       // scaled tolerance
  localparam int CCW = 2 * DW + 1;             // cross product
  localparam int XW  = ((CCW > TW) ? CCW : TW) + 1;
  localparam int BW  = CW + 2;                 // widened bounding box

  // Stage 1: differences, products, scaled tolerance, box and span tests
  logic signed [DW-1:0]   dx, dy, px, py;
  logic [DW-1:0]          adx, ady;
  logic [SW-1:0]          ext_sum;
  logic signed [2*DW-1:0] pa_d, pb_d;
  logic [TW-1:0]          tol_d;
  logic signed [CW-1:0]   lox, hix, loy, hiy;
  logic signed [BW-1:0]   eb, qxb, qyb;
  logic                   box_d, span_d, up_d, down_d;

  assign dx = DW'(ex_i) - DW'(sx_i);
  assign dy = DW'(ey_i) - DW'(sy_i);
  assign px = DW'(qx_i) - DW'(sx_i);
  assign py = DW'(qy_i) - DW'(sy_i);

  assign pa_d = px * dy;
  assign pb_d = py * dx;

  assign adx     = dx[DW-1] ? DW'(-dx) : dx;
  assign ady     = dy[DW-1] ? DW'(-dy) : dy;
  assign ext_sum = SW'(QONE) + SW'(adx) + SW'(ady);
  assign tol_d   = TW'(tol_i) * TW'(ext_sum);

  assign lox = (sx_i < ex_i) ? sx_i : ex_i;
  assign hix = (sx_i < ex_i) ? ex_i : sx_i;
  assign loy = (sy_i < ey_i) ? sy_i : ey_i;
  assign hiy = (sy_i < ey_i) ? ey_i : sy_i;
  assign eb  = signed'(BW'(tol_i));
  assign qxb = BW'(qx_i);
  assign qyb = BW'(qy_i);

  assign box_d = (qxb >= BW'(lox) - eb) && (qxb <= BW'(hix) + eb) &&
                 (qyb >= BW'(loy) - eb) && (qyb <= BW'(hiy) + eb);

  // Half-open rule in y
  assign span_d = ((sy_i <= qy_i) && (ey_i > qy_i)) ||
                  ((sy_i > qy_i) && (ey_i <= qy_i));
  assign up_d   = ey_i > sy_i;
  assign down_d = ey_i < sy_i;

  logic signed [2*DW-1:0] pa_q, pb_q;
  logic [TW-1:0]          tol1_q;
  logic                   ok1_q, box1_q, span1_q, up1_q, down1_q;

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      pa_q    <= pa_d;
      pb_q    <= pb_d;
      tol1_q  <= tol_d;
      ok1_q   <= ok_i;
      box1_q  <= box_d;
      span1_q <= span_d;
      up1_q   <= up_d;
      down1_q <= down_d;
    end
  end

  // Stage 2: cross product
  logic signed [CCW-1:0] c_d, c_q;
  logic [TW-1:0]         tol2_q;
  logic                  ok2_q, box2_q, span2_q, up2_q, down2_q;

  assign c_d = CCW'(pa_q) - CCW'(pb_q);

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      c_q     <= c_d;
      tol2_q  <= tol1_q;
      ok2_q   <= ok1_q;
      box2_q  <= box1_q;
      span2_q <= span1_q;
      up2_q   <= up1_q;
      down2_q <= down1_q;
    end
  end

  // Stage 3: |C| against tolerance, crossing side
  logic signed [XW-1:0] cx, tx, lo_sum;
  logic                 c_neg, c_zero;
  edge_res_t            res_d, res_q;

  assign cx     = XW'(c_q);
  assign tx     = signed'(XW'(tol2_q));
  assign lo_sum = cx + tx;
  assign c_neg  = c_q[CCW-1];
  assign c_zero = (c_q == '0);

  always_comb begin
    res_d.hit  = ok2_q && box2_q && (cx <= tx) && !lo_sum[XW-1];
    res_d.xing = ok2_q && span2_q &&
                 ((up2_q && c_neg) || (down2_q && !c_neg && !c_zero));
    res_d.up   = up2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: sv/pipwt_acc.sv
module pipwt_acc #(
  parameter int WW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic                 geo_i,
  input  pipwt_pkg::edge_res_t res_a_i,
  input  pipwt_pkg::edge_res_t res_b_i,
  input  logic                 nonzero_i,
  input  logic                 m_ready_i,
  output logic                 out_valid_o,
  output logic                 inside_o,
  output logic                 boundary_o
);
  import pipwt_pkg::*;

  function automatic logic signed [WW-1:0] wind_step(input logic signed [WW-1:0] w,
                                                     input edge_res_t r);
    logic signed [WW-1:0] wmax;
    logic signed [WW-1:0] wmin;
    logic signed [WW-1:0] nxt;
    wmax = {1'b0, {(WW-1){1'b1}}};
    wmin = {1'b1, {(WW-1){1'b0}}};
    nxt  = w;
    if (r.xing) begin
      if (r.up) begin
        if (w != wmax) nxt = w + WW'(1);
      end else begin
        if (w != wmin) nxt = w - WW'(1);
      end
    end
    return nxt;
  endfunction

  logic signed [WW-1:0] wind_q, wind_a, wind_d;
  logic                 parity_q, parity_d, bnd_q, bnd_d, rule;
  logic                 out_valid_q, inside_q, boundary_q;

  // Closing edge follows the incoming edge, so saturate in that order
  assign wind_a   = wind_step(wind_q, res_a_i);
  assign wind_d   = wind_step(wind_a, res_b_i);
  assign parity_d = parity_q ^ res_a_i.xing ^ res_b_i.xing;
  assign bnd_d    = bnd_q | res_a_i.hit | res_b_i.hit;
  assign rule     = nonzero_i ? (wind_d != '0) : parity_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wind_q      <= '0;
      parity_q    <= 1'b0;
      bnd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire_i) begin
        if (geo_i) begin
          wind_q   <= '0;
          parity_q <= 1'b0;
          bnd_q    <= 1'b0;
        end else begin
          wind_q   <= wind_d;
          parity_q <= parity_d;
          bnd_q    <= bnd_d;
        end
      end
      if (fire_i && geo_i) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && geo_i) begin
      inside_q   <= bnd_d | rule;
      boundary_q <= bnd_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign inside_o    = inside_q;
  assign boundary_o  = boundary_q;

endmodule

FILE: sv/point_in_polygon_winding_test.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata {vertex_y, vertex_x}, tuser figure_end,
//                                             tlast geometry_end
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata {zeros, on_boundary, inside_res}
// cfg       in   cfg_we_i (no back-pressure)  cfg_addr_i register index, cfg_wdata_i value
//
// One vertex beat is taken every cycle unless a stalled result backs up the stages.
// A beat passes an edge-forming input register, three arithmetic stages per edge
// (products, cross product, compares) and the accumulator, which registers the result.
// Reset clears the pipeline valids, figure tracking and accumulators, and loads the
// register defaults; no clearing pass. A stalled result holds only a geometry-end beat at
// the accumulator stage; beats keep entering while the stages in front still hold bubbles.
module point_in_polygon_winding_test #(
  parameter int COORD_WIDTH   = 32,
  parameter int WINDING_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [CW-1:0] vertex_x, [2CW-1:CW] vertex_y, zero fill to whole bytes
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  input  logic                                   s_axis_tuser,  // figure_end
  input  logic                                   s_axis_tlast,  // geometry_end
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [0] inside_res, [1] on_boundary, [7:2] zero
  output logic [7:0]                             m_axis_tdata,
  input  logic                                   cfg_we_i,
  input  logic [pipwt_pkg::CFG_IDX_W-1:0]        cfg_addr_i,
  input  logic [COORD_WIDTH-1:0]                 cfg_wdata_i
);
  import pipwt_pkg::*;

  localparam int CW = COORD_WIDTH;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] query_x_q, query_y_q;
  logic                 rule_q;
  logic [TOL_W-1:0]     tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x_q <= '0;
      query_y_q <= '0;
      rule_q    <= 1'b0;
      tol_q     <= TOL_W'(TOL_RESET);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_QUERY_X:      query_x_q <= cfg_wdata_i;
        REG_QUERY_Y:      query_y_q <= cfg_wdata_i;
        REG_NONZERO_RULE: rule_q    <= cfg_wdata_i[0];
        REG_BOUNDARY_TOL: tol_q     <= cfg_wdata_i[TOL_W-1:0];
        default:          rule_q    <= rule_q;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: each stage advances when its successor has room
  // ---------------------------------------------------------------------------
  logic v0_q, v1_q, v2_q, v3_q;
  logic geo0_q, geo1_q, geo2_q, geo3_q;
  logic r0, r1, r2, r3, acc_can, fire, out_valid, accept;

  assign acc_can = !geo3_q || !out_valid || m_axis_tready;
  assign r3      = !v3_q || acc_can;
  assign r2      = !v2_q || r3;
  assign r1      = !v1_q || r2;
  assign r0      = !v0_q || r1;
  assign fire    = v3_q && acc_can;

  assign s_axis_tready = r0;
  assign accept        = s_axis_tvalid && r0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r0) v0_q <= s_axis_tvalid;
      if (r1) v1_q <= v0_q;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r0) geo0_q <= s_axis_tlast;
    if (r1) geo1_q <= geo0_q;
    if (r2) geo2_q <= geo1_q;
    if (r3) geo3_q <= geo2_q;
  end

  // ---------------------------------------------------------------------------
  // Figure tracking and edge forming on the accepted beat
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] vin_x, vin_y;
  logic                 fig_end;
  logic                 open_q;           // figure has at least one vertex
  logic signed [CW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;

  assign vin_x   = s_axis_tdata[CW-1:0];
  assign vin_y   = s_axis_tdata[2*CW-1:CW];
  assign fig_end = s_axis_tuser || s_axis_tlast;  // geometry end closes the figure too

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else if (accept) begin
      open_q <= !fig_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!open_q) begin
        first_x_q <= vin_x;
        first_y_q <= vin_y;
      end
      prev_x_q <= vin_x;
      prev_y_q <= vin_y;
    end
  end

  // Edge A: previous vertex to this one. Edge B: closing edge back to the first.
  logic signed [CW-1:0] a_sx_q, a_sy_q, a_ex_q, a_ey_q;
  logic signed [CW-1:0] b_sx_q, b_sy_q, b_ex_q, b_ey_q;
  logic                 a_ok_q, b_ok_q;

  always_ff @(posedge clk_i) begin
    if (r0) begin
      a_sx_q <= prev_x_q;
      a_sy_q <= prev_y_q;
      a_ex_q <= vin_x;
      a_ey_q <= vin_y;
      a_ok_q <= open_q;
      b_sx_q <= vin_x;
      b_sy_q <= vin_y;
      b_ex_q <= first_x_q;
      b_ey_q <= first_y_q;
      b_ok_q <= open_q && fig_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Edge units A and B in lockstep, then the accumulator and result register
  // ---------------------------------------------------------------------------
  edge_res_t res_a, res_b;
  logic      in_res, boundary;

  pipwt_edge #(.CW(CW)) u_edge_a (
    .clk_i (clk_i),
    .en1_i (r1),
    .en2_i (r2),
    .en3_i (r3),
    .ok_i  (a_ok_q),
    .sx_i  (a_sx_q),
    .sy_i  (a_sy_q),
    .ex_i  (a_ex_q),
    .ey_i  (a_ey_q),
    .qx_i  (query_x_q),
    .qy_i  (query_y_q),
    .tol_i (tol_q),
    .res_o (res_a)
  );

  pipwt_edge #(.CW(CW)) u_edge_b (
    .clk_i (clk_i),
    .en1_i (r1),
    .en2_i (r2),
    .en3_i (r3),
    .ok_i  (b_ok_q),
    .sx_i  (b_sx_q),
    .sy_i  (b_sy_q),
    .ex_i  (b_ex_q),
    .ey_i  (b_ey_q),
    .qx_i  (query_x_q),
    .qy_i  (query_y_q),
    .tol_i (tol_q),
    .res_o (res_b)
  );

  pipwt_acc #(.WW(WINDING_WIDTH)) u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .geo_i       (geo3_q),
    .res_a_i     (res_a),
    .res_b_i     (res_b),
    .nonzero_i   (rule_q),
    .m_ready_i   (m_axis_tready),
    .out_valid_o (out_valid),
    .inside_o    (in_res),
    .boundary_o  (boundary)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b000000, boundary, in_res};

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pipwt_pkg::*;

  localparam int COORD_WIDTH   = 32;
  localparam int WINDING_WIDTH = 16;
  localparam int DATA_W        = ((2 * COORD_WIDTH + 7) / 8) * 8;

  // Winding count limits at the block's width
  localparam int WIND_MAX = (1 << (WINDING_WIDTH - 1)) - 1;
  localparam int WIND_MIN = -WIND_MAX - 1;

  // Cycles left for the pipeline to settle after a drain; allow margin
  localparam int SETTLE_CYCLES   = 12;
  // Cycles with no beat on either side before the run is declared hung
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 150;

  typedef struct {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    bit                     fig_end;
    bit                     geo_end;
  } vertex_t;

  typedef struct packed {
    logic in_res;
    logic on_boundary;
  } verdict_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // [31:0] vertex_x, [63:32] vertex_y
  logic [DATA_W-1:0]    s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;  // figure_end
  logic                 s_axis_tlast  = 1'b0;  // geometry_end
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [0] inside_res, [1] on_boundary, [7:2] zero
  logic [7:0]           m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i    = REG_QUERY_X;
  logic [COORD_WIDTH-1:0] cfg_wdata_i = '0;

  // Vertices waiting to be sent; the head stays until its beat is taken
  vertex_t  vertex_q[$];
  // Hit-test verdicts predicted for geometries already sent
  verdict_t verdict_q[$];

  int err_count   = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int run_left    = 0;

  // Shadow of the configuration registers
  longint q_x          = 0;
  longint q_y          = 0;
  bit     fill_nonzero = 1'b0;
  longint tol_eps      = TOL_RESET;

  // Shadow of the accumulators
  longint first_x, first_y, prev_x, prev_y;
  int     fig_vertices;
  bit     ray_parity;
  int     winding;
  bit     edge_hit;

  point_in_polygon_winding_test #(
    .COORD_WIDTH  (COORD_WIDTH),
    .WINDING_WIDTH(WINDING_WIDTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic clear_accumulators();
    first_x      = 0;
    first_y      = 0;
    prev_x       = 0;
    prev_y       = 0;
    fig_vertices = 0;
    ray_parity   = 1'b0;
    winding      = 0;
    edge_hit     = 1'b0;
  endtask

  // Score one edge s->e against the query point: boundary test within the
  // length-scaled tolerance, then the half-open rightward ray crossing.
  task automatic score_edge(input longint sx, input longint sy,
                            input longint ex, input longint ey);
    longint dx, dy, px, py, adx, ady, tol_l;
    longint lox, hix, loy, hiy;
    logic signed [79:0] dxw, dyw, pxw, pyw, cprod, abs_cprod, tolw;
    bit crosses, right_side;
    dx  = ex - sx;
    dy  = ey - sy;
    px  = q_x - sx;
    py  = q_y - sy;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    dxw = dx;
    dyw = dy;
    pxw = px;
    pyw = py;
    // Exact cross product; 80 bits cover the 67-bit worst case
    cprod     = pxw * dyw - pyw * dxw;
    abs_cprod = (cprod < 0) ? -cprod : cprod;
    tol_l     = tol_eps * (longint'(QONE) + adx + ady);
    tolw      = tol_l;
    lox = (sx < ex) ? sx : ex;
    hix = (sx < ex) ? ex : sx;
    loy = (sy < ey) ? sy : ey;
    hiy = (sy < ey) ? ey : sy;
    if (abs_cprod <= tolw &&
        q_x >= lox - tol_eps && q_x <= hix + tol_eps &&
        q_y >= loy - tol_eps && q_y <= hiy + tol_eps) begin
      edge_hit = 1'b1;
    end
    crosses    = (sy <= q_y && ey > q_y) || (sy > q_y && ey <= q_y);
    right_side = (dy > 0 && cprod < 0) || (dy < 0 && cprod > 0);
    if (crosses && right_side) begin
      ray_parity = ~ray_parity;
      // Saturate rather than wrap
      if (ey > sy) begin
        if (winding < WIND_MAX) winding++;
      end else begin
        if (winding > WIND_MIN) winding--;
      end
    end
  endtask

  // Advance the shadow by one vertex; queue a verdict on geometry end
  task automatic predict_vertex(input logic [COORD_WIDTH-1:0] xb,
                                input logic [COORD_WIDTH-1:0] yb,
                                input bit fig, input bit geo);
    longint   vx, vy;
    bit       closing, rule_hit;
    verdict_t verdict;
    vx      = longint'($signed(xb));
    vy      = longint'($signed(yb));
    // Geometry end closes the open figure even without figure end
    closing = fig || geo;
    if (fig_vertices == 0) begin
      first_x = vx;
      first_y = vy;
    end else begin
      score_edge(prev_x, prev_y, vx, vy);
      if (closing) score_edge(vx, vy, first_x, first_y);
    end
    prev_x = vx;
    prev_y = vy;
    if (closing) fig_vertices = 0;
    else if (fig_vertices < 2) fig_vertices++;
    if (geo) begin
      rule_hit            = fill_nonzero ? (winding != 0) : ray_parity;
      verdict.in_res      = edge_hit | rule_hit;
      verdict.on_boundary = edge_hit;
      verdict_q.insert(verdict_q.size(), verdict);
      clear_accumulators();
    end
  endtask

  // Write one register and mirror it in the shadow; call only while idle
  task automatic write_reg(input cfg_reg_e idx, input logic [COORD_WIDTH-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_QUERY_X:      q_x = longint'($signed(val));
      REG_QUERY_Y:      q_y = longint'($signed(val));
      REG_NONZERO_RULE: fill_nonzero = val[0];
      REG_BOUNDARY_TOL: tol_eps = longint'(val[TOL_W-1:0]);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_vertex(input logic [COORD_WIDTH-1:0] x,
                             input logic [COORD_WIDTH-1:0] y,
                             input bit fig, input bit geo);
    vertex_t item;
    item.x       = x;
    item.y       = y;
    item.fig_end = fig;
    item.geo_end = geo;
    vertex_q.insert(vertex_q.size(), item);
  endtask

  // Wait until every vertex is sent and every verdict is back, then let
  // the pipeline settle. Sample at the falling edge, after all beats of the
  // rising edge are booked.
  task automatic drain();
    while (vertex_q.size() != 0 || verdict_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Coordinate near a center, at a mix of scales, with some pure noise
  function automatic logic [COORD_WIDTH-1:0] near_coord(input logic [COORD_WIDTH-1:0] center);
    case ($urandom_range(0, 9))
      0:       return center;
      1, 2:    return center + $urandom_range(0, 512) - 32'd256;
      3, 4, 5: return center + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      6, 7, 8: return center + ($urandom & 32'h0fff_ffff) - 32'h0800_0000;
      default: return $urandom;
    endcase
  endfunction

  // Sender: bursts of random length with random gaps; hold the beat while
  // the block stalls, advance to the next vertex once it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid) void'(vertex_q.pop_front());
      if (gap_left > 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (vertex_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vertex_q[0].y, vertex_q[0].x};
        s_axis_tuser  <= vertex_q[0].fig_end;
        s_axis_tlast  <= vertex_q[0].geo_end;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          // Half the bursts run straight into the next one
          gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: alternate ready and stall runs; mostly short, now and then a
  // long stall or a long ready stretch.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
    end else if (m_axis_tready) begin
      m_axis_tready <= 1'b0;
      run_left      <= ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24)
                                                   : $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
      run_left      <= ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
                                                   : $urandom_range(0, 6);
    end
  end

  // Scoreboard: predict from the vertex beat first, then check the result beat
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_vertex(s_axis_tdata[COORD_WIDTH-1:0],
                       s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH],
                       s_axis_tuser, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          report_error($sformatf("result beat 0x%02h with no verdict pending",
                                 m_axis_tdata));
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata[0] !== want.in_res)
            report_error($sformatf("inside_res got %0b want %0b",
                                   m_axis_tdata[0], want.in_res));
          if (m_axis_tdata[1] !== want.on_boundary)
            report_error($sformatf("on_boundary got %0b want %0b",
                                   m_axis_tdata[1], want.on_boundary));
        end
      end
    end
  end

  // Watchdog: end the run if neither side moves a beat for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int                     phase_items, nfig, nv, r;
    logic [COORD_WIDTH-1:0] vx, vy, lx, ly, sx, sy;
    logic [TOL_W-1:0]       st;
    bit                     sr, fig, geo;
    clear_accumulators();
    lx = '0;
    ly = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, register defaults: query at the origin, even-odd, tol 7
    @(negedge clk_i);
    // Square around the query point
    push_vertex(-655360, -655360, 1'b0, 1'b0);
    push_vertex( 655360, -655360, 1'b0, 1'b0);
    push_vertex( 655360,  655360, 1'b0, 1'b0);
    push_vertex(-655360,  655360, 1'b1, 1'b1);
    // Geometry end without figure end still closes the triangle
    push_vertex(-655360, -655360, 1'b0, 1'b0);
    push_vertex( 655360, -655360, 1'b0, 1'b0);
    push_vertex(      0,  655360, 1'b0, 1'b1);
    // Single-vertex figures have no edges, even on the query point
    push_vertex(      0,       0, 1'b1, 1'b0);
    push_vertex( 131072,  131072, 1'b0, 1'b1);
    // Zero-length edge on the query point: boundary only
    push_vertex(      0,       0, 1'b0, 1'b0);
    push_vertex(      0,       0, 1'b1, 1'b1);
    // Query point on the base of a triangle
    push_vertex(-327680,       0, 1'b0, 1'b0);
    push_vertex( 327680,       0, 1'b0, 1'b0);
    push_vertex(      0,  327680, 1'b1, 1'b1);
    // Extreme coordinates on every corner
    push_vertex(32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
    push_vertex(32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0);
    push_vertex(32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b0);
    push_vertex(32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1);
    // Two nested triangles cancel under even-odd
    push_vertex(-655360, -655360, 1'b0, 1'b0);
    push_vertex( 655360, -655360, 1'b0, 1'b0);
    push_vertex(      0,  655360, 1'b1, 1'b0);
    push_vertex(-327680, -327680, 1'b0, 1'b0);
    push_vertex( 327680, -327680, 1'b0, 1'b0);
    push_vertex(      0,  327680, 1'b1, 1'b1);
    drain();

    // Random phases, each with its own register setting; the first two
    // take the extremes of every register
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          sx = 32'h8000_0000;
          sy = 32'h7fff_ffff;
          sr = 1'b1;
          st = 16'hffff;
        end
        1: begin
          sx = 32'h7fff_ffff;
          sy = 32'h8000_0000;
          sr = 1'b0;
          st = 16'h0000;
        end
        default: begin
          sx = $urandom;
          sy = $urandom;
          sr = $urandom_range(0, 1);
          st = ($urandom_range(0, 2) == 0) ? TOL_W'($urandom) : TOL_W'($urandom_range(0, 64));
        end
      endcase
      write_reg(REG_QUERY_X, sx);
      write_reg(REG_QUERY_Y, sy);
      write_reg(REG_NONZERO_RULE, {{(COORD_WIDTH-1){1'b0}}, sr});
      write_reg(REG_BOUNDARY_TOL, {{(COORD_WIDTH-TOL_W){1'b0}}, st});
      @(negedge clk_i);

      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        nfig = $urandom_range(1, 3);
        for (int f = 0; f < nfig; f++) begin
          case ($urandom_range(0, 9))
            0:       nv = 1;
            1:       nv = 2;
            default: nv = $urandom_range(3, 7);
          endcase
          for (int v = 0; v < nv; v++) begin
            r  = $urandom_range(0, 19);
            vx = near_coord(sx);
            vy = near_coord(sy);
            if (v > 0) begin
              case (r)
                // Repeat the last vertex: zero-length edge
                0: begin
                  vx = lx;
                  vy = ly;
                end
                // Mirror the last vertex through the query point: it sits on the edge
                1: begin
                  vx = (sx << 1) - lx;
                  vy = (sy << 1) - ly;
                end
                // Land on the query row or column: exercise the half-open rule
                2: vy = sy;
                3: vx = sx;
                default: ;
              endcase
            end
            // Mostly well-formed figures, with a stray early figure end now and then
            fig = (v == nv - 1) || ($urandom_range(0, 24) == 0);
            geo = (f == nfig - 1) && (v == nv - 1);
            if (geo && $urandom_range(0, 3) == 0) fig = 1'b0;
            push_vertex(vx, vy, fig, geo);
            lx = vx;
            ly = vy;
            phase_items++;
          end
        end
      end
      drain();
    end

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
